### design/fbs_pkg.sv
// Shared types, constants and helpers for the four-neighbour blur stream.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fbs_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned COL_W  = 8;
  localparam int unsigned ROW_W  = 10;
  localparam int unsigned FW_W   = 9;
  localparam int unsigned FH_W   = 10;
  localparam int unsigned CFG_W  = 10;

  localparam logic [FW_W-1:0] FW_RESET = 9'd160;
  localparam logic [FH_W-1:0] FH_RESET = 10'd120;

  // register indexes on the config port
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int unsigned FIFO_DEPTH = 4;

  // one accepted pixel as seen by the result stage
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col_left;   // x-1
    logic [COL_W-1:0] col_cur;    // x
    logic [ROW_W-1:0] row;        // y-1
    logic             emit_left;  // result for column x-1
    logic             emit_last;  // result for column x (last column)
    logic             have_down;  // not the flush row
    logic             use_up;     // y-1 > 0
    logic             col_nz;     // x > 0
    logic             use_left2;  // x-1 > 0
    logic             last_row;   // y-1 is the frame's last row
  } fbs_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             frame_end;
    logic             run_last;
  } fbs_res_t;

  // window register controls
  typedef struct packed {
    logic shift;    // stage 1 item retires
    logic load_p;   // refill: upper-row taps from read ports
    logic load_qc;  // refill: two-up and current-row taps
  } fbs_win_ctl_t;

  function automatic logic [1:0] prev_line(input logic [1:0] rot);
    unique case (rot)
      2'd0:    prev_line = 2'd2;
      2'd1:    prev_line = 2'd0;
      default: prev_line = 2'd1;
    endcase
  endfunction

  function automatic logic [1:0] prev2_line(input logic [1:0] rot);
    unique case (rot)
      2'd0:    prev2_line = 2'd1;
      2'd1:    prev2_line = 2'd2;
      default: prev2_line = 2'd0;
    endcase
  endfunction

endpackage

### design/four_neighbour_blur_stream_top.sv
// Top level of the four-neighbour blur stream: counters, config, sequencing.
// Depends on fbs_pkg, fbs_line_mem, fbs_window and fbs_out_fifo.
`timescale 1ns / 1ps

// Four-neighbour blur over a raster-order pixel stream.
// - s_axis: one 8-bit pixel per request. After frame_height rows the host
//   sends one more row of frame_width flush requests (data ignored).
// - m_axis: blurred pixel with its column and row; tlast marks the last result
//   caused by one input pixel, tuser marks the frame's last pixel.
// - cfg: write enable, index (0 = frame_width, 1 = frame_height), data.
//   Write only while idle. Each write closes s_axis while the neighbour taps
//   are reloaded from the line store for the next column.
// Throughput: one pixel per clock unless stalled. Each row after the first gives one result
//   per pixel (none at column 0, two at the last column), so the output port
//   also runs at one result per clock; a 4-entry result queue evens it out.
// Path: a pixel and its line store reads are registered into the result stage,
//   which writes its results into the queue that drives m_axis.
// Stall: while m_axis_tready is low the queue fills; once fewer than two
//   slots are free the result stage holds and s_axis_tready drops.
// Reset: counters and rotation clear, registers go to 160 x 120; the line
//   store is not cleared (no entry is used before it is written).
module four_neighbour_blur_stream_top import fbs_pkg::*; #(
  parameter int unsigned MAX_LINE_WIDTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // pixel in
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] pixel_value
  // result out
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] blurred_value, [15:8] out_column,
                                           // [25:16] out_row, [31:26] zero
  output logic             m_axis_tlast,   // run_last
  output logic             m_axis_tuser,   // frame_end
  // config writes
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned MaxW  = MAX_LINE_WIDTH;
  localparam int unsigned CW    = $clog2(MaxW);
  localparam int unsigned Depth = 3 * MaxW;
  localparam int unsigned AW    = $clog2(Depth);

  typedef enum logic [1:0] {ST_RUN, ST_FILL_A, ST_FILL_B, ST_FILL_C} st_e;

  st_e              state_q;
  logic [FW_W-1:0]  fw_q;
  logic [FH_W-1:0]  fh_q;
  logic [CW-1:0]    col_q;
  logic [ROW_W-1:0] row_q;
  logic [1:0]       rot_q;

  logic [CW-1:0]    w_m1, x, xm1, xm2;
  logic [ROW_W-1:0] h_m1;
  logic [1:0]       rot, prv, prv2;
  logic             last_col, flush, accept;

  logic             s1_valid_q;
  fbs_item_t        s1_q, item;
  logic             s1_fire;

  logic             re;
  logic [AW-1:0]    ra0, ra1, wa;
  logic [PIX_W-1:0] rd0, rd1;
  fbs_win_ctl_t     win_ctl;
  fbs_res_t         res_a, res_b, head;
  logic [1:0]       n_res, push_n;
  logic             room;

  function automatic logic [AW-1:0] line_addr(input logic [1:0] line,
                                               input logic [CW-1:0] col);
    line_addr = AW'(line) * AW'(MaxW) + AW'(col);
  endfunction

  // effective frame size and current position
  always_comb begin
    if (fw_q == '0) begin
      w_m1 = '0;
    end else if (32'(fw_q) > MaxW) begin
      w_m1 = CW'(MaxW - 1);
    end else begin
      w_m1 = CW'(fw_q - FW_W'(1));
    end
    h_m1     = (fh_q == '0) ? '0 : fh_q - FH_W'(1);
    rot      = (rot_q == 2'd3) ? 2'd0 : rot_q;
    prv      = prev_line(rot);
    prv2     = prev2_line(rot);
    last_col = (col_q >= w_m1);
    x        = last_col ? w_m1 : col_q;
    xm1      = (x == '0) ? '0 : x - CW'(1);
    xm2      = (x < CW'(2)) ? '0 : x - CW'(2);
    flush    = (row_q > h_m1);
  end

  assign s1_fire       = s1_valid_q && room;
  assign s_axis_tready = (state_q == ST_RUN) && (!s1_valid_q || s1_fire);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item.pixel     = s_axis_tdata;
    item.col_left  = 8'(xm1);
    item.col_cur   = 8'(x);
    item.row       = row_q - ROW_W'(1);
    item.emit_left = (row_q != '0) && (x != '0);
    item.emit_last = (row_q != '0) && last_col;
    item.have_down = !flush;
    item.use_up    = (row_q > ROW_W'(1));
    item.col_nz    = (x != '0);
    item.use_left2 = (x > CW'(1));
    item.last_row  = ((row_q - ROW_W'(1)) == h_m1);
  end

  // line store port selection: normal streaming reads upper rows at x;
  // the refill after a config write fetches the taps behind x
  always_comb begin
    wa = line_addr(rot, x);
    unique case (state_q)
      ST_FILL_A: begin
        re  = 1'b1;
        ra0 = line_addr(prv, xm2);
        ra1 = line_addr(prv, xm1);
      end
      ST_FILL_B: begin
        re  = 1'b1;
        ra0 = line_addr(prv2, xm1);
        ra1 = line_addr(rot, xm1);
      end
      default: begin
        re  = accept;
        ra0 = line_addr(prv, x);
        ra1 = line_addr(prv2, x);
      end
    endcase
    win_ctl.shift   = s1_fire;
    win_ctl.load_p  = (state_q == ST_FILL_B);
    win_ctl.load_qc = (state_q == ST_FILL_C);
    push_n          = s1_fire ? n_res : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      priority if (cfg_we_i) begin
        state_q <= ST_FILL_A;
      end else begin
        unique case (state_q)
          ST_FILL_A: state_q <= ST_FILL_B;
          ST_FILL_B: state_q <= ST_FILL_C;
          default:   state_q <= ST_RUN;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_RESET;
      fh_q <= FH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  fw_q <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_q <= cfg_data_i[FH_W-1:0];
        default:          fw_q <= fw_q;
      endcase
    end
  end

  // frame position counters, advanced per accepted pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      rot_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        if (flush) begin
          row_q <= '0;
          rot_q <= '0;
        end else begin
          row_q <= row_q + ROW_W'(1);
          rot_q <= (rot == 2'd2) ? 2'd0 : rot + 2'd1;
        end
      end else begin
        col_q <= x + CW'(1);
        rot_q <= rot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= item;
    end
  end

  fbs_line_mem #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_line_mem (
    .clk_i    (clk_i),
    .we_i     (accept && !flush),
    .waddr_i  (wa),
    .wdata_i  (s_axis_tdata),
    .re_i     (re),
    .raddr0_i (ra0),
    .raddr1_i (ra1),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  fbs_window u_window (
    .clk_i   (clk_i),
    .item_i  (s1_q),
    .rd0_i   (rd0),
    .rd1_i   (rd1),
    .ctl_i   (win_ctl),
    .res_a_o (res_a),
    .res_b_o (res_b),
    .n_res_o (n_res)
  );

  fbs_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push_a_i (res_a),
    .push_b_i (res_b),
    .room_o   (room),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .head_o   (head)
  );

  assign m_axis_tdata = {6'b0, head.row, head.column, head.value};
  assign m_axis_tlast = head.run_last;
  assign m_axis_tuser = head.frame_end;

  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_q != 2'd3)
    else $error("line rotation out of range");

  a_flush_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_col && flush) |=> (col_q == '0 && row_q == '0 && rot_q == '0))
    else $error("frame counters did not wrap after flush row");

  a_cfg_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("pixel taken during tap refill");

endmodule

### design/fbs_line_mem.sv
// Three-line pixel store: one write port, two registered read ports.
// Depends on fbs_pkg for the pixel width.
`timescale 1ns / 1ps

module fbs_line_mem import fbs_pkg::*; #(
  parameter int unsigned DEPTH = 768,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [PIX_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [PIX_W-1:0] rdata0_o,
  output logic [PIX_W-1:0] rdata1_o
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata0_q, rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem[raddr0_i];
      rdata1_q <= mem[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

### design/fbs_window.sv
// Neighbour window taps and the two blur results of one item.
// Depends on fbs_pkg for item, result and control types.
`timescale 1ns / 1ps

module fbs_window import fbs_pkg::*; (
  input  logic             clk_i,
  input  fbs_item_t        item_i,
  input  logic [PIX_W-1:0] rd0_i,   // upper row at x (refill: various)
  input  logic [PIX_W-1:0] rd1_i,   // two rows up at x (refill: various)
  input  fbs_win_ctl_t     ctl_i,
  output fbs_res_t         res_a_o,
  output fbs_res_t         res_b_o,
  output logic [1:0]       n_res_o
);

  // taps one and two columns behind the item in stage 1
  logic [PIX_W-1:0] p1_q, p2_q, q1_q, c1_q;
  logic [PIX_W+1:0] sum_left, sum_last;
  fbs_res_t         res_left, res_last;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      p2_q <= p1_q;
      p1_q <= rd0_i;
      q1_q <= rd1_i;
      c1_q <= item_i.pixel;
    end else if (ctl_i.load_p) begin
      p2_q <= rd0_i;
      p1_q <= rd1_i;
    end else if (ctl_i.load_qc) begin
      q1_q <= rd0_i;
      c1_q <= rd1_i;
    end
  end

  always_comb begin
    sum_left = (PIX_W+2)'(rd0_i)
             + (item_i.use_left2 ? (PIX_W+2)'(p2_q) : '0)
             + (item_i.use_up    ? (PIX_W+2)'(q1_q) : '0)
             + (item_i.have_down ? (PIX_W+2)'(c1_q) : '0);
    sum_last = (item_i.col_nz    ? (PIX_W+2)'(p1_q) : '0)
             + (item_i.use_up    ? (PIX_W+2)'(rd1_i) : '0)
             + (item_i.have_down ? (PIX_W+2)'(item_i.pixel) : '0);

    res_left.value     = sum_left[PIX_W+1:2];
    res_left.column    = item_i.col_left;
    res_left.row       = item_i.row;
    res_left.frame_end = 1'b0;
    res_left.run_last  = !item_i.emit_last;

    res_last.value     = sum_last[PIX_W+1:2];
    res_last.column    = item_i.col_cur;
    res_last.row       = item_i.row;
    res_last.frame_end = item_i.last_row;
    res_last.run_last  = 1'b1;

    res_a_o = item_i.emit_left ? res_left : res_last;
    res_b_o = res_last;
    n_res_o = 2'(item_i.emit_left) + 2'(item_i.emit_last);
  end

endmodule

### design/fbs_out_fifo.sv
// Result queue: takes up to two results per cycle, gives one.
// Depends on fbs_pkg for the result type and depth.
`timescale 1ns / 1ps

module fbs_out_fifo import fbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  fbs_res_t   push_a_i,
  input  fbs_res_t   push_b_i,
  output logic       room_o,     // space for two more
  output logic       valid_o,
  input  logic       ready_i,
  output fbs_res_t   head_o
);

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  fbs_res_t        entry_q [FIFO_DEPTH];
  logic [PW-1:0]   head_q, tail_q, tail_nx;
  logic [CW-1:0]   count_q, count_d;
  logic            pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[head_q];
  assign room_o  = (count_q <= CW'(FIFO_DEPTH - 2));
  assign tail_nx = tail_q + PW'(1);
  assign count_d = count_q + CW'(push_n_i) - CW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      entry_q[tail_q] <= push_a_i;
    end
    if (push_n_i == 2'd2) begin
      entry_q[tail_nx] <= push_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_q + PW'(pop);
      tail_q  <= tail_q + PW'(push_n_i);
      count_q <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> (count_q <= CW'(FIFO_DEPTH - 2)))
    else $error("result queue pushed without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(FIFO_DEPTH))
    else $error("result queue count out of range");

endmodule

### dv/fbs_stream_checker.sv
// Scoreboard for the four-neighbour blur stream: watches pixel, result and config ports.
// Depends on fbs_pkg for field widths, register indexes and the result struct.
`timescale 1ns / 1ps

module fbs_stream_checker import fbs_pkg::*; #(
  parameter int unsigned MAX_LINE_WIDTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pix_valid_i,
  input  logic             pix_ready_i,
  input  logic [7:0]       pix_data_i,
  input  logic             res_valid_i,
  input  logic             res_ready_i,
  input  logic [31:0]      res_data_i,
  input  logic             res_last_i,
  input  logic             res_user_i,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  logic [PIX_W-1:0] line_copy [3][MAX_LINE_WIDTH];
  int unsigned      col_q;
  int unsigned      row_q;
  int unsigned      rot_q;
  logic [FW_W-1:0]  width_q;
  logic [FH_W-1:0]  height_q;
  fbs_res_t         expected_blur_q [$];

  function automatic logic [PIX_W-1:0] neighbour_avg(input int unsigned c,
                                                     input int unsigned r,
                                                     input int unsigned w,
                                                     input int unsigned rot,
                                                     input bit has_down);
    int unsigned sum;
    int unsigned above;
    int unsigned above2;
    sum    = 0;
    above  = (rot + 2) % 3;
    above2 = (rot + 1) % 3;
    if (c > 0)     sum += line_copy[above][c-1];
    if (c + 1 < w) sum += line_copy[above][c+1];
    if (r > 0)     sum += line_copy[above2][c];
    if (has_down)  sum += line_copy[rot][c];
    return PIX_W'(sum >> 2);
  endfunction

  task automatic note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("%s", msg);
  endtask

  // One accepted pixel: store it and queue the results it releases.
  task automatic predict_blur(input logic [PIX_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned rot;
    int unsigned x;
    int unsigned y;
    bit          flush;
    bit          last_col;
    fbs_res_t    res;
    w = (width_q == 0) ? 1 : ((width_q > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : width_q);
    h = (height_q == 0) ? 1 : height_q;
    rot = (rot_q > 2) ? 0 : rot_q;
    x = col_q;
    y = row_q;
    flush = (y >= h);
    // a shrunk width closes the row at once
    if (x >= w) x = w - 1;
    last_col = (x == w - 1);
    if (!flush) line_copy[rot][x] = pix;
    if (y > 0) begin
      if (x > 0) begin
        res.value     = neighbour_avg(x - 1, y - 1, w, rot, !flush);
        res.column    = COL_W'(x - 1);
        res.row       = ROW_W'(y - 1);
        res.frame_end = 1'b0;
        res.run_last  = !last_col;
        expected_blur_q.push_back(res);
      end
      if (last_col) begin
        res.value     = neighbour_avg(x, y - 1, w, rot, !flush);
        res.column    = COL_W'(x);
        res.row       = ROW_W'(y - 1);
        res.frame_end = (y - 1 == h - 1);
        res.run_last  = 1'b1;
        expected_blur_q.push_back(res);
      end
    end
    if (last_col) begin
      col_q = 0;
      if (flush) begin
        row_q = 0;
        rot_q = 0;
      end else begin
        row_q = (y + 1) & 10'h3ff;
        rot_q = (rot + 1) % 3;
      end
    end else begin
      col_q = x + 1;
      rot_q = rot;
    end
  endtask

  task automatic check_result();
    fbs_res_t got;
    fbs_res_t want;
    got.value     = res_data_i[7:0];
    got.column    = res_data_i[15:8];
    got.row       = res_data_i[25:16];
    got.frame_end = res_user_i;
    got.run_last  = res_last_i;
    if (expected_blur_q.size() == 0) begin
      note_failure($sformatf("unexpected result: value %0d col %0d row %0d end %0b last %0b",
                             got.value, got.column, got.row, got.frame_end, got.run_last));
    end else begin
      want = expected_blur_q.pop_front();
      if (got != want || res_data_i[31:26] != '0) begin
        note_failure($sformatf({"result mismatch: exp value %0d col %0d row %0d end %0b ",
                                "last %0b, got value %0d col %0d row %0d end %0b last %0b ",
                                "pad %0h"},
                               want.value, want.column, want.row, want.frame_end,
                               want.run_last, got.value, got.column, got.row,
                               got.frame_end, got.run_last, res_data_i[31:26]));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < MAX_LINE_WIDTH; j++) line_copy[i][j] = '0;
      col_q    = 0;
      row_q    = 0;
      rot_q    = 0;
      width_q  = FW_RESET;
      height_q = FH_RESET;
      expected_blur_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (pix_valid_i && pix_ready_i) predict_blur(pix_data_i);
      if (res_valid_i && res_ready_i) check_result();
      if (cfg_we_i) begin
        if (cfg_index_i == REG_FRAME_WIDTH) width_q = cfg_data_i[FW_W-1:0];
        else                                height_q = cfg_data_i[FH_W-1:0];
      end
      pending_o = expected_blur_q.size();
    end
  end

endmodule

### dv/testbench.sv
// Top of the blur stream testbench: clock, reset, pixel and config stimulus, verdict.
// Depends on fbs_pkg, four_neighbour_blur_stream_top and fbs_stream_checker.
`timescale 1ns / 1ps

module testbench;
  import fbs_pkg::*;

  localparam int unsigned LINE_MAX    = 256;
  localparam int unsigned DRAIN_WAIT  = 8;       // covers the result stage plus the result queue
  localparam int unsigned PHASE_ITEMS = 60;      // minimum random pixels per idling phase
  localparam int unsigned CYCLE_LIMIT = 300000;  // several times the slowest legal run

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [31:0]      m_axis_tdata;
  logic             m_axis_tlast;
  logic             m_axis_tuser;
  logic             cfg_we_i      = 1'b0;
  logic             cfg_index_i   = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data_i    = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;  // chance per cycle that the sender holds off
  int unsigned recv_stall_pct = 0; // chance per cycle that the sink drops tready

  always #4 clk_i = ~clk_i;

  four_neighbour_blur_stream_top #(.MAX_LINE_WIDTH(LINE_MAX)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  fbs_stream_checker #(.MAX_LINE_WIDTH(LINE_MAX)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_i  (s_axis_tready),
    .pix_data_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_last_i   (m_axis_tlast),
    .res_user_i   (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Sink side: tready is rolled fresh every cycle.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Called at a falling edge, returns at a falling edge right after the request is taken.
  // tvalid is only lowered on an idle roll, so back-to-back requests keep it high.
  task automatic send_pixel(input logic [7:0] pix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Drop tvalid, let every queued result drain, then wait out DRAIN_WAIT for the
  // pixels that release no result (first row, column 0).
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Full frame plus its flush row; w_reg/h_reg are raw register values,
  // out-of-range ones are clamped by the block the same way as here.
  task automatic run_frame(input int unsigned w_reg, input int unsigned h_reg,
                           output int unsigned sent);
    int unsigned w_eff;
    int unsigned h_eff;
    w_eff = (w_reg == 0) ? 1 : ((w_reg > LINE_MAX) ? LINE_MAX : w_reg);
    h_eff = (h_reg == 0) ? 1 : h_reg;
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w_reg);
    write_reg(REG_FRAME_HEIGHT, h_reg);
    sent = w_eff * (h_eff + 1);
    for (int unsigned i = 0; i < sent; i++) send_pixel(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase_items;
    int unsigned w_pick;
    int unsigned h_pick;
    int unsigned roll;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // --- directed ---
    // 3x3 checkerboard of 0/255: centre sees four 255s (sum 1020, no overflow),
    // edges and corners exercise the zero padding; then the flush row.
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++) send_pixel(((x + y) % 2) ? 8'd255 : 8'd0);
    for (int x = 0; x < 3; x++) send_pixel(8'($urandom_range(0, 255)));

    // width shrinks mid row: the next pixel is forced to be the last column
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 4);
    write_reg(REG_FRAME_HEIGHT, 2);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd128);
    send_pixel(8'd1);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 2);
    send_pixel(8'd254);
    send_pixel(8'($urandom_range(0, 255)));
    send_pixel(8'($urandom_range(0, 255)));

    // height shrinks mid frame: the current row turns into the flush row
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 4);
    for (int i = 0; i < 5; i++) send_pixel(8'($urandom_range(0, 255)));
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 2);
    send_pixel(8'($urandom_range(0, 255)));

    // --- random frames, four idling phases ---
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      // one odd-size frame per phase: width 0 (used as 1) over many rows,
      // the widest line via an out-of-range width with height 0 (used as 1),
      // a narrow tall frame, then the smallest frame
      case (phase)
        0: run_frame(0, 40, sent);
        1: run_frame(511, 0, sent);
        2: run_frame(2, 30, sent);
        default: run_frame(1, 1, sent);
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 5)       w_pick = 0;
        else if (roll < 15) w_pick = $urandom_range(13, 32);
        else                w_pick = $urandom_range(1, 12);
        h_pick = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 6);
        run_frame(w_pick, h_pick, sent);
        phase_items += sent;
      end
    end

    // drain what is left, then a short tail for stray results
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### four_neighbour_blur_stream_top.f
design/fbs_pkg.sv
design/fbs_line_mem.sv
design/fbs_window.sv
design/fbs_out_fifo.sv
design/four_neighbour_blur_stream_top.sv
dv/fbs_stream_checker.sv
dv/testbench.sv
